/* rtl/rau_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int unsigned DefWidth = 32;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_OVF  = 2'd2,
    ST_RSVD = 2'd3
  } status_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE    = 4'd0,
    OP_LOAD    = 4'd1,  // split operands, set x=ad, y=bd for the LCM gcd
    OP_GSTEP   = 4'd2,  // start one x mod y division
    OP_DSTEP   = 4'd3,  // one restoring divider bit
    OP_GNEXT   = 4'd4,  // x<=y, y<=remainder
    OP_LCMDIV  = 4'd5,  // start q = ad / g
    OP_MUL1    = 4'd6,  // first product of the step
    OP_MUL2    = 4'd7,  // second product of the step
    OP_COMB    = 4'd8,  // combine terms into n, d
    OP_RGCD    = 4'd9,  // set x=n, y=d for the reduce gcd
    OP_RDIVN   = 4'd10, // start n / g
    OP_RDIVD   = 4'd11, // start d / g
    OP_FIN     = 4'd12, // range check and build the result
    OP_LCMDIV2 = 4'd13  // keep q = ad / g, start bd / g
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   mstep;     // which multiply pair: 0 first, 1 second
  } dp_cmd_t;

  typedef struct packed {
    logic bad;         // zero denominator or divide by zero
    logic is_muldiv;
    logic y_zero;
    logic div_done;
  } dp_status_t;

endpackage : rau_pkg
`default_nettype wire

/* rtl/rational_arithmetic_unit_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top
// Rational add, subtract, multiply and divide with GCD reduction.
// ----------------------------------------------------------------------------
// One transaction at a time. A multiply or divide runs the reducing
// Euclidean loop; add and subtract also run, before it, the loop that finds
// the common denominator. Both loops, the two LCM quotients and the two
// final divisions share one bit-serial restoring divider. Errors (zero
// denominator, divide by zero) are offered straight after the load state
// and return 0/0 with status 1; overflow returns 0/0 with status 2.
module rational_arithmetic_unit_top
  import rau_pkg::*;
#(
  parameter int unsigned WIDTH = DefWidth
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [135:0] s_tdata,  // cmd, a_num, a_den, b_num, b_den, pad
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [71:0]       m_tdata   // res_num, res_den, status, pad
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_LOAD = 10'b0000000010,
    S_GCD  = 10'b0000000100,
    S_DIV  = 10'b0000001000,
    S_MUL1 = 10'b0000010000,
    S_MUL2 = 10'b0000100000,
    S_COMB = 10'b0001000000,
    S_RED  = 10'b0010000000,
    S_FIN  = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_t;

  // Phase within the shared-divider flow.
  typedef enum logic [2:0] {
    P_LGCD, P_LQ, P_LQ2, P_RGCD, P_RN, P_RD
  } phase_t;

  state_t     state;
  phase_t     phase;
  dp_cmd_t    dcmd;
  dp_status_t dstat;
  logic [31:0] r_num;
  logic [30:0] r_den;
  logic [1:0]  r_st;
  logic        err;

  rau_datapath #(.WIDTH(WIDTH)) u_dp (
    .clk     (clk),
    .cmd_in  (dcmd),
    .op_code (s_tdata[1:0]),
    .a_num   (s_tdata[33:2]),
    .a_den   (s_tdata[65:34]),
    .b_num   (s_tdata[97:66]),
    .b_den   (s_tdata[129:98]),
    .stat    (dstat),
    .res_num (r_num),
    .res_den (r_den),
    .status  (r_st)
  );

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = err ? {7'd0, ST_ZERO, 31'd0, 32'd0}
                        : {7'd0, r_st, r_den, r_num};

  always_comb begin
    dcmd.op    = OP_NONE;
    dcmd.mstep = (state == S_MUL2);
    unique case (state)
      S_IDLE: if (s_tvalid) dcmd.op = OP_LOAD;
      S_GCD:  dcmd.op = dstat.y_zero ? (phase == P_LGCD ? OP_LCMDIV : OP_RDIVN)
                                     : OP_GSTEP;
      S_DIV: begin
        if (!dstat.div_done) begin
          dcmd.op = OP_DSTEP;
        end else if (phase == P_LGCD || phase == P_RGCD) begin
          dcmd.op = OP_GNEXT;
        end else if (phase == P_LQ) begin
          dcmd.op = OP_LCMDIV2;
        end else if (phase == P_RN) begin
          dcmd.op = OP_RDIVD;
        end
      end
      S_MUL1: dcmd.op = OP_MUL1;
      S_MUL2: dcmd.op = OP_MUL2;
      S_COMB: dcmd.op = OP_COMB;
      S_RED:  dcmd.op = OP_RGCD;
      S_FIN:  dcmd.op = OP_FIN;
      default: dcmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= P_LGCD;
      err   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (s_tvalid) begin
          state <= S_LOAD;
          phase <= P_LGCD;
          err   <= 1'b0;
        end
        S_LOAD: begin
          if (dstat.bad) begin
            err <= 1'b1; state <= S_OUT;
          end else if (dstat.is_muldiv) state <= S_MUL1;
          else state <= S_GCD;
        end
        S_GCD: begin
          if (dstat.y_zero) begin
            phase <= (phase == P_LGCD) ? P_LQ : P_RN;
          end
          state <= S_DIV;
        end
        S_DIV: if (dstat.div_done) begin
          priority case (phase)
            P_LGCD, P_RGCD: state <= S_GCD;
            P_LQ:           phase <= P_LQ2;
            P_LQ2:          state <= S_MUL1;
            P_RN:           phase <= P_RD;
            default:        state <= S_FIN;
          endcase
        end
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_COMB;
        S_COMB: state <= S_RED;
        S_RED: begin
          phase <= P_RGCD;
          state <= S_GCD;
        end
        S_FIN: state <= S_OUT;
        S_OUT: if (m_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule : rational_arithmetic_unit_top
`default_nettype wire

/* rtl/rau_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rau_datapath
// Operand registers, a shared restoring divider, a multiplier and the
// result formatting of the rational arithmetic unit.
// ----------------------------------------------------------------------------
module rau_datapath
  import rau_pkg::*;
#(
  parameter int unsigned WIDTH = DefWidth
) (
  input  wire logic        clk,
  input  wire dp_cmd_t     cmd_in,
  input  wire logic [1:0]  op_code,
  input  wire logic [31:0] a_num,
  input  wire logic [31:0] a_den,
  input  wire logic [31:0] b_num,
  input  wire logic [31:0] b_den,
  output dp_status_t       stat,
  output logic [31:0]      res_num,
  output logic [30:0]      res_den,
  output logic [1:0]       status
);

  localparam int unsigned DW = 2 * WIDTH;
  localparam int unsigned CW = $clog2(DW + 1);

  logic [WIDTH-1:0] an, ad, bn, bd, q;
  logic             sa, sb;
  logic [1:0]       opc;
  logic [DW-1:0]    x, y, n, d, t1, t2;
  logic             neg;
  // Restoring divider.
  logic [DW-1:0]    dv_num, dv_den, dv_quo, dv_rem;
  logic [CW-1:0]    dv_cnt;

  function automatic logic [WIDTH-1:0] mag(input logic [31:0] v);
    logic [WIDTH-1:0] w;
    w = v[WIDTH-1:0];
    return w[WIDTH-1] ? (~w + 1'b1) : w;
  endfunction

  logic [DW-1:0] rem_sh;
  logic          ge;
  assign rem_sh = {dv_rem[DW-2:0], dv_num[DW-1]};
  assign ge     = (dv_rem[DW-1] == 1'b1) || (rem_sh >= dv_den);

  // Single multiplier, shared by all product steps.
  logic [WIDTH-1:0] m_a, m_b;
  logic [DW-1:0]    m_p;
  assign m_p = DW'(m_a) * DW'(m_b);

  logic          s2;
  assign s2 = (opc == CMD_SUB) ? ~sb : sb;

  always_comb begin
    m_a = '0;
    m_b = '0;
    if (opc == CMD_MUL) begin
      m_a = cmd_in.mstep ? ad : an;
      m_b = cmd_in.mstep ? bd : bn;
    end else if (opc == CMD_DIV) begin
      m_a = cmd_in.mstep ? ad : an;
      m_b = cmd_in.mstep ? bn : bd;
    end else if (cmd_in.op == OP_COMB) begin
      // lcm = (ad/g)*bd.
      m_a = q;
      m_b = bd;
    end else begin
      // t1 = (bd/g)*an with bd/g still in the divider; t2 = (ad/g)*bn.
      m_a = cmd_in.mstep ? q : dv_quo[WIDTH-1:0];
      m_b = cmd_in.mstep ? bn : an;
    end
  end

  logic [DW-1:0] half;
  assign half = DW'(1) << (WIDTH - 1);

  always_ff @(posedge clk) begin
    unique case (cmd_in.op)
      OP_LOAD: begin
        an  <= mag(a_num);
        ad  <= mag(a_den);
        bn  <= mag(b_num);
        bd  <= mag(b_den);
        sa  <= a_num[WIDTH-1] ^ a_den[WIDTH-1];
        sb  <= b_num[WIDTH-1] ^ b_den[WIDTH-1];
        opc <= op_code;
        x   <= DW'(mag(a_den));
        y   <= DW'(mag(b_den));
      end
      OP_GSTEP: begin
        dv_num <= x;
        dv_den <= y;
        dv_rem <= '0;
        dv_cnt <= CW'(DW);
      end
      OP_LCMDIV: begin
        dv_num <= DW'(ad);
        dv_den <= x;
        dv_rem <= '0;
        dv_cnt <= CW'(DW);
      end
      OP_LCMDIV2: begin
        q      <= dv_quo[WIDTH-1:0];
        dv_num <= DW'(bd);
        dv_den <= x;
        dv_rem <= '0;
        dv_cnt <= CW'(DW);
      end
      OP_RDIVN: begin
        dv_num <= n;
        dv_den <= x;
        dv_rem <= '0;
        dv_cnt <= CW'(DW);
      end
      OP_RDIVD: begin
        n      <= dv_quo;
        dv_num <= d;
        dv_den <= x;
        dv_rem <= '0;
        dv_cnt <= CW'(DW);
      end
      OP_DSTEP: begin
        dv_num <= {dv_num[DW-2:0], 1'b0};
        dv_rem <= ge ? (rem_sh - dv_den) : rem_sh;
        dv_quo <= {dv_quo[DW-2:0], ge};
        dv_cnt <= dv_cnt - 1'b1;
      end
      OP_GNEXT: begin
        x <= y;
        y <= dv_rem;
      end
      OP_MUL1: begin
        t1 <= m_p;
      end
      OP_MUL2: begin
        t2 <= m_p;
      end
      OP_COMB: begin
        if (opc == CMD_MUL || opc == CMD_DIV) begin
          n   <= t1;
          d   <= t2;
          neg <= sa ^ sb;
        end else begin
          d <= m_p;
          if (sa == s2) begin
            n <= t1 + t2; neg <= sa;
          end else if (t1 >= t2) begin
            n <= t1 - t2; neg <= sa;
          end else begin
            n <= t2 - t1; neg <= s2;
          end
        end
      end
      OP_RGCD: begin
        x <= n;
        y <= d;
      end
      OP_FIN: begin
        if (dv_quo > half - 1'b1 || (neg ? (n > half) : (n > half - 1'b1))) begin
          res_num <= '0;
          res_den <= '0;
          status  <= ST_OVF;
        end else begin
          res_num <= 32'(signed'(neg ? (DW'(0) - n) : n));
          res_den <= 31'(dv_quo);
          status  <= ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  assign stat.bad = (ad == '0) || (bd == '0) || (opc == CMD_DIV && bn == '0);
  assign stat.is_muldiv = (opc == CMD_MUL) || (opc == CMD_DIV);
  assign stat.y_zero = (y == '0);
  assign stat.div_done = (dv_cnt == '0);

endmodule : rau_datapath
`default_nettype wire
